/* src/assert_macros.svh */
// Assertion macros used by the checker file of the block allocator.
// Depends on nothing; the user module must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside of reset
`define BBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
// Used by the datapath, the controller, the top level and the checker.
`default_nettype none

package bba_pkg;

    // Fixed field widths
    localparam int LIMIT_W  = 11;
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    typedef logic [STATUS_W-1:0] t_status;

    // Result status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_BAD_INDEX = 2'd2;

    // Request type codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic    clr_wr;    // write a zero word at the sweep address
        logic    load_req;  // take the request item and restart the scan
        logic    scan;      // read the next map word
        logic    upd_wr;    // write the updated word back, adjust the used count
        logic    finish;    // capture the result of this item
        t_status status;    // status code to capture on finish
        logic    load_out;  // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // sweep address is at the last word
        logic req_free;  // pending item is a free request
        logic idx_bad;   // free index at or beyond the managed count
        logic n_zero;    // no blocks managed
        logic hit;       // checked word holds the answer
        logic last;      // checked word is the last managed word
    } t_dp_sts;

endpackage

`default_nettype wire

/* src/bba_datapath.sv */
// Datapath of the bitmap allocator: map memory, scan counters, used count,
// limit register and result registers. Depends on bba_pkg.
`default_nettype none

module bba_datapath #(
    parameter int NUM_BLOCKS    = 1024,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bba_pkg::t_dp_cmd             i_cmd,
    output bba_pkg::t_dp_sts                  o_sts,
    input  wire logic                         i_req_type,
    input  wire logic [bba_pkg::IDX_W-1:0]    i_block_index,
    input  wire logic                         i_cfg_we,
    input  wire logic [bba_pkg::LIMIT_W-1:0]  i_cfg_data,
    output logic [bba_pkg::IDX_W-1:0]         o_granted_index,
    output bba_pkg::t_status                  o_status,
    output logic [bba_pkg::LIMIT_W-1:0]       o_free_count
);

    localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int POS_W     = $clog2(MAP_WORD_BITS);
    localparam int SPAN      = MAP_WORDS * MAP_WORD_BITS;
    localparam int BW        = $clog2(SPAN + 1);
    localparam int NW        = (BW > bba_pkg::LIMIT_W) ? BW : bba_pkg::LIMIT_W;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
    localparam logic [NW-1:0] WORD_SPAN = NW'(MAP_WORD_BITS);
    localparam logic [NW-1:0] NUM_N     = NW'(NUM_BLOCKS);

    // Map memory
    logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] r_rdata;

    // Registers
    logic [bba_pkg::LIMIT_W-1:0] r_limit;
    logic                        r_req_type;
    logic [bba_pkg::IDX_W-1:0]   r_idx;
    logic [AW-1:0]               r_addr;
    logic [NW-1:0]               r_base;
    logic [AW-1:0]               r_chk_addr;
    logic [NW-1:0]               r_chk_base;
    logic                        r_chk_vld;
    logic [NW-1:0]               r_used;
    logic [bba_pkg::IDX_W-1:0]   r_res_granted;
    bba_pkg::t_status            r_res_status;
    logic [bba_pkg::IDX_W-1:0]   r_out_granted;
    bba_pkg::t_status            r_out_status;
    logic [bba_pkg::LIMIT_W-1:0] r_out_free;

    // Combinational signals
    logic [NW-1:0]            lim_ext;
    logic [NW-1:0]            count_n;
    logic [NW-1:0]            idx_ext;
    logic [NW-1:0]            rem;
    logic [NW-1:0]            off;
    logic [MAP_WORD_BITS-1:0] avail;
    logic [POS_W-1:0]         alloc_pos;
    logic [POS_W-1:0]         sel_pos;
    logic [MAP_WORD_BITS-1:0] bit_mask;
    logic [MAP_WORD_BITS-1:0] new_word;
    logic [NW-1:0]            grant_full;
    logic                     in_word;
    logic                     alloc_hit;
    logic                     was_used;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [MAP_WORD_BITS-1:0] wr_data;

    // Managed count: limit saturated to the block count
    assign lim_ext = NW'(r_limit);
    assign count_n = (lim_ext > NUM_N) ? NUM_N : lim_ext;
    assign idx_ext = NW'(r_idx);

    // Free bits of the checked word that lie below the managed count
    assign rem = count_n - r_chk_base;
    always_comb begin
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            avail[b] = !r_rdata[b] && (NW'(b) < rem);
        end
    end

    // Lowest free bit
    always_comb begin
        alloc_pos = '0;
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                alloc_pos = POS_W'(b);
            end
        end
    end
    assign alloc_hit = |avail;

    // Position of the freed block within the checked word
    assign off     = idx_ext - r_chk_base;
    assign in_word = (idx_ext >= r_chk_base) && (off < WORD_SPAN);

    assign sel_pos    = r_req_type ? off[POS_W-1:0] : alloc_pos;
    assign bit_mask   = MAP_WORD_BITS'(1) << sel_pos;
    assign new_word   = r_req_type ? (r_rdata & ~bit_mask) : (r_rdata | bit_mask);
    assign was_used   = |(r_rdata & bit_mask);
    assign grant_full = r_chk_base + NW'(alloc_pos);

    // Status toward the controller
    always_comb begin
        o_sts.clr_last = (r_addr == LAST_ADDR);
        o_sts.req_free = r_req_type;
        o_sts.idx_bad  = (idx_ext >= count_n);
        o_sts.n_zero   = (count_n == '0);
        o_sts.hit      = r_chk_vld && (r_req_type ? in_word : alloc_hit);
        o_sts.last     = r_chk_vld && ((r_chk_base + WORD_SPAN) >= count_n);
    end

    // Memory write port: clearing sweep or word update
    assign wr_en   = i_cmd.clr_wr || i_cmd.upd_wr;
    assign wr_addr = i_cmd.clr_wr ? r_addr : r_chk_addr;
    assign wr_data = i_cmd.clr_wr ? '0 : new_word;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.scan) begin
            r_rdata <= mem[r_addr];
        end
    end

    // Limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bba_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Scan counters and sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_base     <= '0;
            r_chk_addr <= '0;
            r_chk_base <= '0;
            r_chk_vld  <= 1'b0;
        end else if (i_cmd.load_req) begin
            r_addr    <= '0;
            r_base    <= '0;
            r_chk_vld <= 1'b0;
        end else if (i_cmd.clr_wr) begin
            r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + AW'(1);
        end else if (i_cmd.scan) begin
            r_chk_addr <= r_addr;
            r_chk_base <= r_base;
            r_chk_vld  <= 1'b1;
            if (r_addr != LAST_ADDR) begin
                r_addr <= r_addr + AW'(1);
                r_base <= r_base + WORD_SPAN;
            end
        end
    end

    // Used block count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.upd_wr) begin
            if (r_req_type == bba_pkg::REQ_ALLOC) begin
                r_used <= r_used + NW'(1);
            end else if (was_used && (r_used != '0)) begin
                r_used <= r_used - NW'(1);
            end
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_type <= i_req_type;
            r_idx      <= i_block_index;
        end
    end

    // Result capture and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_status <= i_cmd.status;
            if ((i_cmd.status == bba_pkg::ST_OK) && (r_req_type == bba_pkg::REQ_ALLOC)) begin
                r_res_granted <= grant_full[bba_pkg::IDX_W-1:0];
            end else begin
                r_res_granted <= '0;
            end
        end
        if (i_cmd.load_out) begin
            r_out_granted <= r_res_granted;
            r_out_status  <= r_res_status;
            if (count_n > r_used) begin
                r_out_free <= bba_pkg::LIMIT_W'(count_n - r_used);
            end else begin
                r_out_free <= '0;
            end
        end
    end

    assign o_granted_index = r_out_granted;
    assign o_status        = r_out_status;
    assign o_free_count    = r_out_free;

endmodule

`default_nettype wire

/* src/bba_ctrl.sv */
// Controller of the bitmap allocator: clearing sweep, request sequencing
// and both handshakes. Depends on bba_pkg.
`default_nettype none

module bba_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire bba_pkg::t_dp_sts  i_sts,
    output bba_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_out_vld;
    logic   out_free;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    // Decode commands from state and datapath status
    always_comb begin
        o_cmd = '0;
        o_cmd.status = bba_pkg::ST_OK;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_cmd.load_req = i_in_valid;
            end
            S_CHECK: begin
                if (i_sts.req_free && i_sts.idx_bad) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = bba_pkg::ST_BAD_INDEX;
                end else if (!i_sts.req_free && i_sts.n_zero) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = bba_pkg::ST_FULL;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.upd_wr = 1'b1;
                end else if (i_sts.last) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = bba_pkg::ST_FULL;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= o_cmd.finish ? S_COMMIT : S_SCAN;
                end
                S_SCAN: begin
                    if (o_cmd.finish) r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/block_bitmap_allocator_top.sv */
// Sequence: an accepted item is checked, then the map is scanned from word 0 up to the
// word that answers (free: word of the index; allocate: first word with a free block, or
// the last managed word if none); a bad index or no blocks skips the scan. One item is
// handled at a time; the map memory read port gives one word per cycle.
// Reset: synchronous; a clearing sweep zeroes every map word before the first item is taken;
// configuration writes are taken at any time.
`default_nettype none

module block_bitmap_allocator_top #(
    parameter int NUM_BLOCKS    = 1024,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_req_type,
    input  wire logic [bba_pkg::IDX_W-1:0]    i_block_index,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [bba_pkg::IDX_W-1:0]         o_granted_index,
    output logic [bba_pkg::STATUS_W-1:0]      o_status,
    output logic [bba_pkg::LIMIT_W-1:0]       o_free_count,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [bba_pkg::LIMIT_W-1:0]  i_cfg_data
);

    bba_pkg::t_dp_cmd cmd;
    bba_pkg::t_dp_sts sts;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bba_datapath #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req_type),
        .i_block_index   (i_block_index),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .o_free_count    (o_free_count)
    );

endmodule

`default_nettype wire

/* src/bba_checker.sv */
// Port-level checker of the bitmap allocator and its bind to the top level.
// Depends on bba_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bba_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         o_in_ready,
    input  wire logic                         o_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [bba_pkg::IDX_W-1:0]    o_granted_index,
    input  wire logic [bba_pkg::STATUS_W-1:0] o_status,
    input  wire logic [bba_pkg::LIMIT_W-1:0]  o_free_count
);

    // Reset leaves no result pending and runs the clearing sweep first
    `BBA_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> (!o_out_valid && !o_in_ready), "output or input live right after reset")

    // Only a successful allocation carries a nonzero index
    `BBA_ASSERT(a_grant_zero, (o_out_valid && (o_status != bba_pkg::ST_OK)) |-> (o_granted_index == '0), "granted index nonzero on failed request")

    // One item in flight: no accept right after an accept
    `BBA_ASSERT(a_one_at_a_time, (i_in_valid && o_in_ready) |=> !o_in_ready, "ready again right after an accept")

    // A stalled result holds
    `BBA_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status) && $stable(o_granted_index) && $stable(o_free_count)), "stalled result changed")

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_granted_index (o_granted_index),
    .o_status        (o_status),
    .o_free_count    (o_free_count)
);

`default_nettype wire

/* sim/tb_block_bitmap_allocator_top.sv */
`timescale 1ns / 1ps
// Testbench for the bitmap first-fit block allocator top level.
// Depends on bba_pkg and block_bitmap_allocator_top; keeps its own used map and
// block limit, predicts every reply and checks it field by field.

module tb_block_bitmap_allocator_top;

    localparam int NUM_BLOCKS  = 1024;
    localparam int QUIET_LIMIT = 3000;
    localparam int MAX_SHOWN   = 10;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [bba_pkg::IDX_W-1:0]   granted;
        bba_pkg::t_status            status;
        logic [bba_pkg::LIMIT_W-1:0] free_left;
    } t_alloc_reply;

    // DUT connections; the inputs are known from time zero
    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         in_valid       = 1'b0;
    logic                         in_req_type    = bba_pkg::REQ_ALLOC;
    logic [bba_pkg::IDX_W-1:0]    in_block_index = '0;
    logic                         out_ready      = 1'b0;
    logic                         cfg_valid      = 1'b0;
    logic [bba_pkg::LIMIT_W-1:0]  cfg_data       = '0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic [bba_pkg::IDX_W-1:0]    o_granted_index;
    logic [bba_pkg::STATUS_W-1:0] o_status;
    logic [bba_pkg::LIMIT_W-1:0]  o_free_count;
    logic                         o_cfg_ready;

    // Local copy of the allocator state
    bit                          block_used [NUM_BLOCKS];
    int unsigned                 used_total = 0;
    logic [bba_pkg::LIMIT_W-1:0] limit_reg  = bba_pkg::LIMIT_RESET;

    t_alloc_reply owed_replies [$];
    int           mismatches   = 0;
    int           quiet_cycles = 0;
    bit           idle_on      = 1'b1;
    int           hold_request = 0;

    block_bitmap_allocator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (in_req_type),
        .i_block_index   (in_block_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .o_free_count    (o_free_count),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Effective number of managed blocks: register saturated at the map size
    function automatic int managed_blocks();
        return (limit_reg > NUM_BLOCKS) ? NUM_BLOCKS : int'(limit_reg);
    endfunction

    // Apply one request to the local map and return the reply it yields
    function automatic t_alloc_reply apply_request(logic req,
                                                   logic [bba_pkg::IDX_W-1:0] idx);
        t_alloc_reply r;
        int n;
        int i;
        n = managed_blocks();
        r.granted = '0;
        r.status  = bba_pkg::ST_OK;
        if (req == bba_pkg::REQ_ALLOC) begin
            r.status = bba_pkg::ST_FULL;
            for (i = 0; i < n; i++) begin
                if (!block_used[i]) begin
                    block_used[i] = 1'b1;
                    used_total++;
                    r.granted = bba_pkg::IDX_W'(i);
                    r.status  = bba_pkg::ST_OK;
                    break;
                end
            end
        end else if (int'(idx) >= n) begin
            r.status = bba_pkg::ST_BAD_INDEX;
        end else if (block_used[idx]) begin
            block_used[idx] = 1'b0;
            if (used_total > 0) used_total--;
        end
        r.free_left = (n > used_total) ? bba_pkg::LIMIT_W'(n - used_total) : '0;
        return r;
    endfunction

    // Choose a block to free: mostly a used one, else anywhere, else past the limit
    function automatic logic [bba_pkg::IDX_W-1:0] pick_free_index();
        int n;
        int roll;
        int probe;
        int k;
        n     = managed_blocks();
        roll  = $urandom_range(0, 99);
        probe = 0;
        if (roll < 60 && n > 0) begin
            for (k = 0; k < 8; k++) begin
                probe = $urandom_range(0, n - 1);
                if (block_used[probe]) return bba_pkg::IDX_W'(probe);
            end
            return bba_pkg::IDX_W'(probe);
        end
        if (roll < 85 || n >= NUM_BLOCKS)
            return bba_pkg::IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
        return bba_pkg::IDX_W'($urandom_range(n, NUM_BLOCKS - 1));
    endfunction

    // Offer one item, hold it until taken, then record its reply
    task automatic send_request(input logic req, input logic [bba_pkg::IDX_W-1:0] idx);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid       <= 1'b1;
        in_req_type    <= req;
        in_block_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        owed_replies.push_back(apply_request(req, idx));
    endtask

    // Drop the input and wait for every owed reply plus a short settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (owed_replies.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the block limit once the allocator is idle
    task automatic write_limit(input logic [bba_pkg::LIMIT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    task automatic run_random_phase(input logic [bba_pkg::LIMIT_W-1:0] value,
                                    input int count, input int alloc_pct);
        int k;
        logic req;
        write_limit(value);
        for (k = 0; k < count; k++) begin
            req = ($urandom_range(0, 99) < alloc_pct) ? bba_pkg::REQ_ALLOC
                                                      : bba_pkg::REQ_FREE;
            send_request(req, (req == bba_pkg::REQ_ALLOC) ? bba_pkg::IDX_W'($urandom)
                                                          : pick_free_index());
        end
    endtask

    // Lowest-free order, free of an unused block, top index, out of range, full, shrunk and
    // saturated limit
    task automatic test_directed_corners();
        int k;
        send_request(bba_pkg::REQ_ALLOC, '1);
        send_request(bba_pkg::REQ_ALLOC, '0);
        send_request(bba_pkg::REQ_ALLOC, 10'h155);
        send_request(bba_pkg::REQ_FREE, 10'd1);
        send_request(bba_pkg::REQ_ALLOC, 10'h2AA);
        send_request(bba_pkg::REQ_FREE, 10'd500);
        send_request(bba_pkg::REQ_FREE, 10'd1023);
        write_limit(11'd8);
        send_request(bba_pkg::REQ_FREE, 10'd1023);
        send_request(bba_pkg::REQ_FREE, 10'd8);
        send_request(bba_pkg::REQ_FREE, 10'd7);
        for (k = 0; k < 6; k++) send_request(bba_pkg::REQ_ALLOC, bba_pkg::IDX_W'($urandom));
        write_limit(11'd2);
        send_request(bba_pkg::REQ_ALLOC, '0);
        send_request(bba_pkg::REQ_FREE, 10'd5);
        send_request(bba_pkg::REQ_FREE, 10'd0);
        write_limit(11'h7FF);
        send_request(bba_pkg::REQ_ALLOC, '0);
        send_request(bba_pkg::REQ_ALLOC, '1);
    endtask

    // Random mixes over several limits, one of them without idling
    task automatic test_random_mix();
        run_random_phase(11'h7FF, 240, 70);
        run_random_phase(11'd16, 160, 50);
        run_random_phase(11'd1, 60, 50);
        idle_on = 1'b0;
        run_random_phase(11'd100, 220, 60);
        idle_on = 1'b1;
        run_random_phase(11'd1024, 180, 55);
    endtask

    // No managed blocks: every allocate full, every free invalid
    task automatic test_zero_limit();
        int k;
        write_limit(11'd0);
        for (k = 0; k < 20; k++) begin
            if (k[0]) send_request(bba_pkg::REQ_FREE, bba_pkg::IDX_W'($urandom));
            else send_request(bba_pkg::REQ_ALLOC, bba_pkg::IDX_W'($urandom));
        end
    endtask

    // Long receiver hold while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        int k;
        write_limit(11'd1024);
        idle_on      = 1'b0;
        hold_request = 300;
        for (k = 0; k < 12; k++) begin
            if (k % 3 == 2) send_request(bba_pkg::REQ_FREE, pick_free_index());
            else send_request(bba_pkg::REQ_ALLOC, bba_pkg::IDX_W'($urandom));
        end
        idle_on = 1'b1;
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial begin : drive_out_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each taken reply with the oldest owed one
    always @(posedge i_clk) begin : check_replies
        t_alloc_reply want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (owed_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected reply: granted %0d status %0d free %0d",
                             o_granted_index, o_status, o_free_count);
            end else begin
                want = owed_replies.pop_front();
                if (o_granted_index !== want.granted || o_status !== want.status ||
                    o_free_count !== want.free_left) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("reply mismatch: granted %0d/%0d status %0d/%0d free %0d/%0d",
                                 want.granted, o_granted_index, want.status, o_status,
                                 want.free_left, o_free_count);
                end
            end
        end
    end

    // Watchdog: end the run after too long without any handshake
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin : run_tests
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_corners();
        test_random_mix();
        test_zero_limit();
        test_output_backpressure();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && owed_replies.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
